// File: hdl/efa_pkg.sv
// Shared types and constants of the extent free-list block allocator.
`timescale 1ns / 1ps

package efa_pkg;

   localparam int BLOCK_W  = 10;
   localparam int COUNT_W  = 11;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;

   localparam logic [BLOCK_W-1:0] FIRST_DATA_BLOCK = BLOCK_W'(2);
   localparam logic [COUNT_W-1:0] COUNT_MAX        = {COUNT_W{1'b1}};
   localparam logic [COUNT_W-1:0] VOLUME_RESET     = COUNT_W'(1024);

   localparam logic [OP_W-1:0] OP_FORMAT = 2'd0;
   localparam logic [OP_W-1:0] OP_ALLOC  = 2'd1;
   localparam logic [OP_W-1:0] OP_FREE   = 2'd2;
   localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [BLOCK_W-1:0] block;
   } req_payload_type;

   typedef struct packed {
      logic [BLOCK_W-1:0]  block_out;
      logic [COUNT_W-1:0]  free_count;
      logic [STATUS_W-1:0] status;
   } rsp_payload_type;

   // Run header kept in the first block of every free run.
   typedef struct packed {
      logic [COUNT_W-1:0] run_length;
      logic [BLOCK_W-1:0] next_run;
   } header_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic accept;
      logic execute;
   } ctl_cmd_type;

endpackage

// File: hdl/efa_stream_if.sv
// Valid/ready stream interface carrying one payload.
`timescale 1ns / 1ps

interface efa_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/efa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module efa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/efa_ctrl.sv
// Allocator controller: request sequencing and result valid.
`timescale 1ns / 1ps

module efa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output efa_pkg::ctl_cmd_type cmd
);
   import efa_pkg::*;

   typedef enum logic {
      IDLE,
      EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   assign req_ready   = (state_ff == IDLE);
   assign cmd.accept  = (state_ff == IDLE) && req_valid;
   // Execute only once the result slot is free or drains this cycle.
   assign cmd.execute = (state_ff == EXEC) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         IDLE: begin
            if (cmd.accept) begin
               state_in = EXEC;
            end
         end
         EXEC: begin
            if (cmd.execute) begin
               state_in     = IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hdl/efa_datapath.sv
// Allocator datapath: head, free count, volume register, header RAM, result register.
`timescale 1ns / 1ps

module efa_datapath #(
   parameter int NUM_BLOCKS = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  efa_pkg::ctl_cmd_type               cmd,
   input  efa_pkg::req_payload_type           req_payload,
   output efa_pkg::rsp_payload_type           rsp_payload,
   input  logic                               csr_we,
   input  logic [efa_pkg::COUNT_W-1:0]        csr_wdata
);
   import efa_pkg::*;

   localparam int AW = $clog2(NUM_BLOCKS);

   logic [OP_W-1:0]    op_ff;
   logic [BLOCK_W-1:0] blk_ff;
   logic [BLOCK_W-1:0] head_ff;
   logic [BLOCK_W-1:0] head_in;
   logic [COUNT_W-1:0] total_ff;
   logic [COUNT_W-1:0] total_in;
   logic [COUNT_W-1:0] volume_ff;
   rsp_payload_type    rsp_ff;
   rsp_payload_type    rsp_in;

   header_type         rd_hdr;
   header_type         wr_hdr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [AW-1:0]      head_idx;

   logic [31:0]        vs32;
   logic [COUNT_W-1:0] fmt_count;
   logic [31:0]        nh32;
   logic               blk_ok;

   // Out-of-range block numbers map to entry zero.
   function automatic logic [AW-1:0] idx_of(input logic [BLOCK_W-1:0] b);
      if (32'(b) < 32'(NUM_BLOCKS)) begin
         return AW'(b);
      end
      return '0;
   endfunction

   assign head_idx = idx_of(head_ff);

   efa_ram #(
      .WIDTH ($bits(header_type)),
      .DEPTH (NUM_BLOCKS)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_hdr),
      .rd_en   (cmd.accept),
      .rd_addr (head_idx),
      .rd_data (rd_hdr)
   );

   always_comb begin
      vs32 = 32'(volume_ff);
      if (vs32 > 32'(NUM_BLOCKS)) begin
         vs32 = 32'(NUM_BLOCKS);
      end
      fmt_count = (vs32 > 32'(FIRST_DATA_BLOCK)) ?
                  COUNT_W'(vs32 - 32'(FIRST_DATA_BLOCK)) : '0;
      nh32 = 32'(head_idx) + 32'd1;
      if (nh32 >= 32'(NUM_BLOCKS)) begin
         nh32 = '0;
      end
      blk_ok = (blk_ff != '0) && (32'(blk_ff) < 32'(NUM_BLOCKS));
   end

   always_comb begin
      head_in          = head_ff;
      total_in         = total_ff;
      wr_en            = 1'b0;
      wr_addr          = '0;
      wr_hdr           = '0;
      rsp_in           = rsp_ff;
      rsp_in.block_out = '0;
      rsp_in.status    = ST_OK;
      unique case (op_ff)
         OP_FORMAT: begin
            head_in           = FIRST_DATA_BLOCK;
            total_in          = fmt_count;
            wr_en             = 1'b1;
            wr_addr           = idx_of(FIRST_DATA_BLOCK);
            wr_hdr.run_length = fmt_count;
            wr_hdr.next_run   = '0;
         end
         OP_ALLOC: begin
            if (total_ff == '0) begin
               rsp_in.status = ST_NOSPACE;
            end else begin
               rsp_in.block_out = head_ff;
               total_in         = total_ff - COUNT_W'(1);
               if (rd_hdr.run_length <= COUNT_W'(1)) begin
                  // Single-block run: unlink it.
                  head_in = rd_hdr.next_run;
               end else begin
                  // Advance head and shrink the run header.
                  head_in           = BLOCK_W'(nh32);
                  wr_en             = 1'b1;
                  wr_addr           = AW'(nh32);
                  wr_hdr.run_length = rd_hdr.run_length - COUNT_W'(1);
                  wr_hdr.next_run   = rd_hdr.next_run;
               end
            end
         end
         OP_FREE: begin
            if (!blk_ok) begin
               rsp_in.status = ST_IGNORED;
            end else begin
               wr_en             = 1'b1;
               wr_addr           = AW'(blk_ff);
               wr_hdr.run_length = COUNT_W'(1);
               wr_hdr.next_run   = head_ff;
               head_in           = blk_ff;
               if (total_ff < COUNT_MAX) begin
                  total_in = total_ff + COUNT_W'(1);
               end
            end
         end
         OP_NOP: begin
         end
         default: begin
         end
      endcase
      rsp_in.free_count = total_in;
      if (!cmd.execute) begin
         head_in  = head_ff;
         total_in = total_ff;
         wr_en    = 1'b0;
         rsp_in   = rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         total_ff  <= '0;
         volume_ff <= VOLUME_RESET;
      end else begin
         head_ff  <= head_in;
         total_ff <= total_in;
         if (csr_we) begin
            volume_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_payload.op;
         blk_ff <= req_payload.block;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

endmodule

// File: hdl/extent_free_list_block_allocator.sv
// Top level of the extent free-list block allocator.
//
//   channel   direction  handshake        payload
//   req       in         valid/ready      op, block
//   rsp       out        valid/ready      block_out, free_count, status
//   csr       in         csr_we           csr_wdata (volume_size)
//
// For each request the head run header is read from the header RAM on accept
// (registered read), then the updated header is written and the result register
// loads. Reset clears head and free count and sets volume size to 1024; run
// headers are not cleared and hold nothing until format, allocate or free
// writes them.
// A held result does not block the next request from being accepted; that
// request executes once the result register drains.
`timescale 1ns / 1ps

module extent_free_list_block_allocator #(
   parameter int NUM_BLOCKS = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   efa_stream_if.sink                  req,
   efa_stream_if.source                rsp,
   input  logic                        csr_we,
   input  logic [efa_pkg::COUNT_W-1:0] csr_wdata
);
   import efa_pkg::*;

   ctl_cmd_type cmd;

   efa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   efa_datapath #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req.payload),
      .rsp_payload (rsp.payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

endmodule

// File: hdl/efa_checker.sv
// Port-level checks on the allocator, bound to the top level.
`timescale 1ns / 1ps

module efa_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [efa_pkg::BLOCK_W-1:0]  rsp_block_out,
   input logic [efa_pkg::COUNT_W-1:0]  rsp_free_count,
   input logic [efa_pkg::STATUS_W-1:0] rsp_status
);
   import efa_pkg::*;

   // A held result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_block_out) &&
      $stable(rsp_free_count) && $stable(rsp_status))
      else $error("rsp payload changed while stalled");

   // One request in flight: ready drops right after accept.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req accepted while previous request in flight");

   // A new result must follow an accepted request.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("rsp valid rose without matching request");

   // No-space result carries an empty list and no block.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_NOSPACE) |->
      (rsp_free_count == '0) && (rsp_block_out == '0))
      else $error("no-space result with nonzero count or block");

endmodule

bind extent_free_list_block_allocator efa_checker u_efa_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_block_out  (rsp.payload.block_out),
   .rsp_free_count (rsp.payload.free_count),
   .rsp_status     (rsp.payload.status)
);

// File: bench/testbench.sv
// Self-checking testbench for the extent free-list block allocator.
`timescale 1ns / 1ps

module testbench;
   import efa_pkg::*;

   localparam int NUM_BLOCKS = 1024;
   localparam int CYCLE_LIMIT = 500000;

   typedef enum bit {ROW_REQ, ROW_CSR} row_kind_e;

   typedef struct {
      row_kind_e          kind;
      logic [COUNT_W-1:0] volume;
      logic [OP_W-1:0]    op;
      logic [BLOCK_W-1:0] block;
      bit                 typed;
      logic [BLOCK_W-1:0] want_block;
      logic [COUNT_W-1:0] want_count;
      logic [STATUS_W-1:0] want_status;
   } dir_row_t;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [COUNT_W-1:0] csr_wdata;

   efa_stream_if #(.payload_type(req_payload_type)) req ();
   efa_stream_if #(.payload_type(rsp_payload_type)) rsp ();

   extent_free_list_block_allocator #(.NUM_BLOCKS(NUM_BLOCKS)) uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // Allocator state as predicted from accepted requests.
   logic [COUNT_W-1:0] vol_size = VOLUME_RESET;
   logic [BLOCK_W-1:0] head_blk = '0;
   logic [COUNT_W-1:0] free_cnt = '0;
   logic [COUNT_W-1:0] run_len [NUM_BLOCKS];
   logic [BLOCK_W-1:0] next_blk [NUM_BLOCKS];
   bit                 hdr_valid [NUM_BLOCKS];

   rsp_payload_type    pending_results [$];
   logic [BLOCK_W-1:0] held_blocks [$];
   int unsigned        fail_count = 0;
   int unsigned        burst_left = 0;
   int unsigned        cycle_count = 0;
   int unsigned        rx_cycle = 0;
   int unsigned        rx_hold_left = 0;
   int unsigned        rx_mode = 0;
   rsp_payload_type    seen_want;

   dir_row_t directed_steps [33] = '{
      '{ROW_REQ, 11'd0,    OP_ALLOC,  10'd0,    1'b1, 10'd0,    11'd0,    ST_NOSPACE},
      '{ROW_REQ, 11'd0,    OP_FREE,   10'd0,    1'b1, 10'd0,    11'd0,    ST_IGNORED},
      '{ROW_REQ, 11'd0,    OP_FREE,   10'd1023, 1'b1, 10'd0,    11'd1,    ST_OK},
      '{ROW_REQ, 11'd0,    OP_ALLOC,  10'd0,    1'b1, 10'd1023, 11'd0,    ST_OK},
      '{ROW_REQ, 11'd0,    OP_NOP,    10'd1023, 1'b1, 10'd0,    11'd0,    ST_OK},
      '{ROW_CSR, 11'd2,    OP_NOP,    10'd0,    1'b0, 10'd0,    11'd0,    ST_OK},
      '{ROW_REQ, 11'd0,    OP_FORMAT, 10'd0,    1'b1, 10'd0,    11'd0,    ST_OK},
      '{ROW_REQ, 11'd0,    OP_ALLOC,  10'd0,    1'b1, 10'd0,    11'd0,    ST_NOSPACE},
      '{ROW_CSR, 11'd3,    OP_NOP,    10'd0,    1'b0, 10'd0,    11'd0,    ST_OK},
      '{ROW_REQ, 11'd0,    OP_FORMAT, 10'd0,    1'b1, 10'd0,    11'd1,    ST_OK},
      '{ROW_REQ, 11'd0,    OP_ALLOC,  10'd0,    1'b1, 10'd2,    11'd0,    ST_OK},
      '{ROW_REQ, 11'd0,    OP_ALLOC,  10'd0,    1'b1, 10'd0,    11'd0,    ST_NOSPACE},
      '{ROW_CSR, 11'd4,    OP_NOP,    10'd0,    1'b0, 10'd0,    11'd0,    ST_OK},
      '{ROW_REQ, 11'd0,    OP_FORMAT, 10'd0,    1'b1, 10'd0,    11'd2,    ST_OK},
      '{ROW_REQ, 11'd0,    OP_ALLOC,  10'd0,    1'b1, 10'd2,    11'd1,    ST_OK},
      '{ROW_REQ, 11'd0,    OP_ALLOC,  10'd0,    1'b1, 10'd3,    11'd0,    ST_OK},
      '{ROW_CSR, 11'd2047, OP_NOP,    10'd0,    1'b0, 10'd0,    11'd0,    ST_OK},
      '{ROW_REQ, 11'd0,    OP_FORMAT, 10'd0,    1'b1, 10'd0,    11'd1022, ST_OK},
      '{ROW_REQ, 11'd0,    OP_ALLOC,  10'd0,    1'b1, 10'd2,    11'd1021, ST_OK},
      '{ROW_REQ, 11'd0,    OP_FREE,   10'd5,    1'b0, 10'd0,    11'd0,    ST_OK},
      '{ROW_REQ, 11'd0,    OP_ALLOC,  10'd0,    1'b0, 10'd0,    11'd0,    ST_OK},
      '{ROW_REQ, 11'd0,    OP_ALLOC,  10'd0,    1'b0, 10'd0,    11'd0,    ST_OK},
      '{ROW_REQ, 11'd0,    OP_FREE,   10'd682,  1'b0, 10'd0,    11'd0,    ST_OK},
      '{ROW_REQ, 11'd0,    OP_FREE,   10'd341,  1'b0, 10'd0,    11'd0,    ST_OK},
      '{ROW_REQ, 11'd0,    OP_ALLOC,  10'd1023, 1'b0, 10'd0,    11'd0,    ST_OK},
      '{ROW_CSR, 11'd0,    OP_NOP,    10'd0,    1'b0, 10'd0,    11'd0,    ST_OK},
      '{ROW_REQ, 11'd0,    OP_FORMAT, 10'd0,    1'b1, 10'd0,    11'd0,    ST_OK},
      '{ROW_CSR, 11'd1,    OP_NOP,    10'd0,    1'b0, 10'd0,    11'd0,    ST_OK},
      '{ROW_REQ, 11'd0,    OP_FORMAT, 10'd0,    1'b1, 10'd0,    11'd0,    ST_OK},
      '{ROW_CSR, 11'd1024, OP_NOP,    10'd0,    1'b0, 10'd0,    11'd0,    ST_OK},
      '{ROW_REQ, 11'd0,    OP_FORMAT, 10'd0,    1'b1, 10'd0,    11'd1022, ST_OK},
      '{ROW_REQ, 11'd0,    OP_ALLOC,  10'd0,    1'b1, 10'd2,    11'd1021, ST_OK},
      '{ROW_REQ, 11'd0,    OP_NOP,    10'd0,    1'b0, 10'd0,    11'd0,    ST_OK}
   };

   // Work out the response to one request and advance the allocator state.
   function automatic rsp_payload_type apply_request(input req_payload_type item);
      rsp_payload_type    r;
      logic [COUNT_W-1:0] span;
      logic [COUNT_W-1:0] len;
      logic [BLOCK_W-1:0] nxt;
      logic [BLOCK_W-1:0] nh;
      r = '0;
      case (item.op)
         OP_FORMAT: begin
            span = (vol_size > NUM_BLOCKS) ? COUNT_W'(NUM_BLOCKS) : vol_size;
            span = (span > FIRST_DATA_BLOCK) ? span - FIRST_DATA_BLOCK : '0;
            head_blk = FIRST_DATA_BLOCK;
            free_cnt = span;
            run_len[FIRST_DATA_BLOCK] = span;
            next_blk[FIRST_DATA_BLOCK] = '0;
            hdr_valid[FIRST_DATA_BLOCK] = 1'b1;
         end
         OP_ALLOC: begin
            if (free_cnt == '0) begin
               r.status = ST_NOSPACE;
            end else begin
               len = run_len[head_blk];
               nxt = next_blk[head_blk];
               r.block_out = head_blk;
               // a run of one block unlinks, a longer run shrinks by one
               if (len <= 1) begin
                  head_blk = nxt;
               end else begin
                  nh = (head_blk == NUM_BLOCKS - 1) ? '0 : head_blk + 1'b1;
                  run_len[nh] = len - 1'b1;
                  next_blk[nh] = nxt;
                  hdr_valid[nh] = 1'b1;
                  head_blk = nh;
               end
               free_cnt = free_cnt - 1'b1;
            end
         end
         OP_FREE: begin
            if (item.block == '0 || int'(item.block) >= NUM_BLOCKS) begin
               r.status = ST_IGNORED;
            end else begin
               run_len[item.block] = COUNT_W'(1);
               next_blk[item.block] = head_blk;
               hdr_valid[item.block] = 1'b1;
               head_blk = item.block;
               if (free_cnt != COUNT_MAX) free_cnt = free_cnt + 1'b1;
            end
         end
         default: begin
         end
      endcase
      r.free_count = free_cnt;
      return r;
   endfunction

   // Never let an allocate read a run header that was never written.
   function automatic req_payload_type guard_alloc(input req_payload_type item);
      req_payload_type g;
      g = item;
      if (g.op == OP_ALLOC && free_cnt != '0 && !hdr_valid[head_blk]) g.op = OP_NOP;
      return g;
   endfunction

   task automatic send_item(input req_payload_type item, input bit typed,
                            input rsp_payload_type want, output rsp_payload_type got);
      int unsigned gap;
      req.valid <= 1'b1;
      req.payload <= item;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      got = apply_request(item);
      pending_results.push_back(typed ? want : got);
      if (got.status == ST_OK && item.op == OP_ALLOC) held_blocks.push_back(got.block_out);
      if (item.op == OP_FORMAT) held_blocks.delete();
      // bursts of back-to-back requests separated by random gaps
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap != 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Drain the block, then write the volume size.
   task automatic write_volume(input logic [COUNT_W-1:0] v);
      req.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      vol_size = v;
   endtask

   // Stimulus
   initial begin
      req_payload_type item;
      rsp_payload_type want;
      rsp_payload_type got;
      int unsigned     phase_len;
      int unsigned     pick;
      int unsigned     idx;
      req.valid <= 1'b0;
      req.payload <= '0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      reset <= 1'b1;
      foreach (hdr_valid[i]) begin
         hdr_valid[i] = 1'b0;
         run_len[i] = '0;
         next_blk[i] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == ROW_CSR) begin
            write_volume(directed_steps[i].volume);
         end else begin
            item.op = directed_steps[i].op;
            item.block = directed_steps[i].block;
            want.block_out = directed_steps[i].want_block;
            want.free_count = directed_steps[i].want_count;
            want.status = directed_steps[i].want_status;
            send_item(item, directed_steps[i].typed, want, got);
         end
      end

      // Mixed traffic: format a volume, then allocate and free against it, with occasional no-ops and reformats.
      for (int phase = 0; phase < 11; phase++) begin
         case (phase)
            0: write_volume(11'd3);
            1: write_volume(11'd4);
            2: write_volume(11'd2047);
            3: write_volume(11'd1025);
            4: write_volume(11'd0);
            5: write_volume(11'd5);
            default: begin
               if ($urandom_range(0, 2) == 0) write_volume(COUNT_W'($urandom_range(3, 2047)));
               else write_volume(COUNT_W'($urandom_range(3, 40)));
            end
         endcase
         item.op = OP_FORMAT;
         item.block = BLOCK_W'($urandom_range(0, 1023));
         send_item(item, 1'b0, want, got);
         phase_len = $urandom_range(35, 65);
         for (int k = 0; k < phase_len; k++) begin
            pick = $urandom_range(0, 99);
            item.block = BLOCK_W'($urandom_range(0, 1023));
            if (pick < 48) begin
               item.op = OP_ALLOC;
            end else if (pick < 88) begin
               item.op = OP_FREE;
               // mostly return a block that was handed out, sometimes anything
               if (held_blocks.size() != 0 && $urandom_range(0, 3) != 0) begin
                  idx = $urandom_range(0, held_blocks.size() - 1);
                  item.block = held_blocks[idx];
                  held_blocks.delete(idx);
               end else if ($urandom_range(0, 15) == 0) begin
                  item.block = '0;
               end
            end else if (pick < 95) begin
               item.op = OP_NOP;
            end else begin
               item.op = OP_FORMAT;
            end
            send_item(guard_alloc(item), 1'b0, want, got);
         end
      end

      // Push the free count into saturation, then drain a little.
      write_volume(11'd1024);
      item.op = OP_FORMAT;
      item.block = '0;
      send_item(item, 1'b0, want, got);
      pick = 0;
      while (free_cnt != COUNT_MAX || pick < 10) begin
         if (free_cnt == COUNT_MAX) pick++;
         item.op = OP_FREE;
         item.block = ($urandom_range(0, 31) == 0) ? '0 : BLOCK_W'($urandom_range(1, 1023));
         send_item(item, 1'b0, want, got);
      end
      for (int k = 0; k < 25; k++) begin
         item.op = ($urandom_range(0, 4) == 0) ? OP_FREE : OP_ALLOC;
         item.block = BLOCK_W'($urandom_range(0, 1023));
         send_item(guard_alloc(item), 1'b0, want, got);
      end

      req.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Response side: changing stall patterns plus periodic long hold-offs.
   initial begin
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (rx_hold_left != 0) begin
            rx_hold_left--;
            rsp.ready <= 1'b0;
         end else if (rx_cycle % 4000 == 1500) begin
            rx_hold_left = 150;
            rsp.ready <= 1'b0;
         end else begin
            if (rx_cycle % 200 == 0) rx_mode = $urandom_range(0, 3);
            case (rx_mode)
               0: rsp.ready <= 1'b1;
               1: rsp.ready <= ($urandom_range(0, 1) == 0);
               2: rsp.ready <= ($urandom_range(0, 3) == 0);
               default: rsp.ready <= (rx_cycle % 8 < 5);
            endcase
         end
      end
   end

   // Compare every accepted response with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_results.size() == 0) begin
            $error("response with no request outstanding: block_out %0d free_count %0d status %0d",
                   rsp.payload.block_out, rsp.payload.free_count, rsp.payload.status);
            fail_count++;
         end else begin
            seen_want = pending_results.pop_front();
            if (rsp.payload.block_out !== seen_want.block_out) begin
               $error("block_out: expected %0d, got %0d", seen_want.block_out,
                      rsp.payload.block_out);
               fail_count++;
            end
            if (rsp.payload.free_count !== seen_want.free_count) begin
               $error("free_count: expected %0d, got %0d", seen_want.free_count,
                      rsp.payload.free_count);
               fail_count++;
            end
            if (rsp.payload.status !== seen_want.status) begin
               $error("status: expected %0d, got %0d", seen_want.status, rsp.payload.status);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

endmodule
